// ----- sv/mcdtc_pkg.sv -----
// ----------------------------------------------------------------------------
// Debounce trigger counter package
// Shared constants, codes and types of the multi-channel debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdtc_pkg;

   localparam int CHANNELS    = 6;
   localparam int MAX_CH      = 6;
   localparam int TALLY_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int TIME_WIDTH  = 32;
   localparam int DEB_WIDTH   = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic             LOW_TRIP_RESET = 1'b1;
   localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = DEB_WIDTH'(20);

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_REINIT = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW_TRIP = 2'd0,
      REG_DEBOUNCE = 2'd1
   } reg_index_type;

   typedef struct packed {
      logic                  fire;
      kind_type              kind;
      logic [TIME_WIDTH-1:0] now;
      logic                  low_trip;
      logic [DEB_WIDTH-1:0]  debounce;
   } chan_ctl_type;

endpackage

`default_nettype wire

// ----- sv/mcdtc_channel.sv -----
// ----------------------------------------------------------------------------
// Debounce channel
// State and update logic of one limit input: raw change time, debounced
// level, trigger state and wrapping trigger tally.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdtc_channel
   import mcdtc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire chan_ctl_type           ctl,
   input  wire logic                   raw,
   output logic                        level_in,
   output logic [TALLY_WIDTH-1:0]      tally_in
);

   logic                  prev_ff, prev_in;
   logic                  level_ff;
   logic                  trig_ff, trig_in;
   logic [TIME_WIDTH-1:0] change_ff, change_in;
   logic [TALLY_WIDTH-1:0] tally_ff;

   logic [TIME_WIDTH-1:0] elapsed;
   logic                  adopt;
   logic                  raw_trig;

   always_comb begin
      prev_in   = prev_ff;
      level_in  = level_ff;
      trig_in   = trig_ff;
      change_in = change_ff;
      tally_in  = tally_ff;
      raw_trig  = raw ^ ctl.low_trip;
      elapsed   = '0;
      adopt     = 1'b0;
      if (ctl.fire) begin
         case (ctl.kind)
            KIND_REINIT: begin
               prev_in   = raw;
               level_in  = raw;
               trig_in   = raw_trig;
               change_in = ctl.now;
               tally_in  = '0;
            end
            default: begin
               prev_in = raw;
               if (raw != prev_ff) begin
                  change_in = ctl.now;
               end
               elapsed = ctl.now - change_in;
               adopt   = (elapsed >= TIME_WIDTH'(ctl.debounce)) && (level_ff != raw);
               if (adopt) begin
                  level_in = raw;
                  trig_in  = raw_trig;
                  if (raw_trig && !trig_ff) begin
                     tally_in = tally_ff + TALLY_WIDTH'(1);
                  end
               end
               if (ctl.kind == KIND_CLEAR) begin
                  tally_in = '0;
                  trig_in  = level_in ^ ctl.low_trip;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b0;
         level_ff  <= 1'b0;
         trig_ff   <= 1'b0;
         change_ff <= '0;
         tally_ff  <= '0;
      end else begin
         prev_ff   <= prev_in;
         level_ff  <= level_in;
         trig_ff   <= trig_in;
         change_ff <= change_in;
         tally_ff  <= tally_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/multi_channel_debounce_trigger_counter.sv -----
// ----------------------------------------------------------------------------
// Multi-channel debounce trigger counter
// Six limit inputs debounced in parallel against a millisecond timestamp,
// with a wrapping trigger count per channel.
// ----------------------------------------------------------------------------
// Each beat on the request side carries raw pin levels and a timestamp and
// yields exactly one response beat with the echoed levels, the debounced
// levels, the triggered mask and all six trigger counts. The block takes one
// beat per cycle while the response side does not stall; a beat is held in
// the input register, where all channels update in parallel, and then in the
// output register that drives the response. Send a reinitialize beat first
// and after any register write. Register writes are accepted at any time but
// must only be made while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_debounce_trigger_counter
   import mcdtc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_kind,
   input  wire logic [MAX_CH-1:0]      req_raw_levels,
   input  wire logic [TIME_WIDTH-1:0]  req_now_ms,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [MAX_CH-1:0]           rsp_raw_echo,
   output logic [MAX_CH-1:0]           rsp_debounced_levels,
   output logic [MAX_CH-1:0]           rsp_triggered_mask,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch0,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch1,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch2,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch3,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch4,
   output logic [COUNT_WIDTH-1:0]      rsp_count_ch5,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                  low_trip_ff;
   logic [DEB_WIDTH-1:0]  debounce_ff;

   logic                  in_valid_ff;
   logic [1:0]            in_kind_ff;
   logic [MAX_CH-1:0]     in_raw_ff;
   logic [TIME_WIDTH-1:0] in_now_ff;

   logic                  out_valid_ff;
   logic [MAX_CH-1:0]     out_raw_ff;
   logic [MAX_CH-1:0]     out_level_ff;
   logic [MAX_CH-1:0]     out_trig_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff [MAX_CH];

   logic                  advance;
   logic                  fire;
   chan_ctl_type          ctl;
   logic [MAX_CH-1:0]     level_in;
   logic [MAX_CH-1:0]     trig_in;
   logic [COUNT_WIDTH-1:0] count_in [MAX_CH];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_trip_ff <= LOW_TRIP_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_LOW_TRIP: low_trip_ff <= csr_wdata[0];
            REG_DEBOUNCE: debounce_ff <= csr_wdata[DEB_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_raw_ff  <= req_raw_levels;
         in_now_ff  <= req_now_ms;
      end
   end

   assign ctl = '{fire:     fire,
                  kind:     kind_type'(in_kind_ff),
                  now:      in_now_ff,
                  low_trip: low_trip_ff,
                  debounce: debounce_ff};

   for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_chan
      if (ch < CHANNELS) begin : g_live
         logic                   lvl;
         logic [TALLY_WIDTH-1:0] tally;

         mcdtc_channel u_channel (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .raw      (in_raw_ff[ch]),
            .level_in (lvl),
            .tally_in (tally)
         );

         assign level_in[ch] = lvl;
         assign trig_in[ch]  = lvl ^ low_trip_ff;
         assign count_in[ch] = COUNT_WIDTH'(tally);
      end else begin : g_none
         assign level_in[ch] = 1'b0;
         assign trig_in[ch]  = 1'b0;
         assign count_in[ch] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_raw_ff   <= in_raw_ff;
         out_level_ff <= level_in;
         out_trig_ff  <= trig_in;
         out_count_ff <= count_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_raw_echo         = out_raw_ff;
   assign rsp_debounced_levels = out_level_ff;
   assign rsp_triggered_mask   = out_trig_ff;
   assign rsp_count_ch0        = out_count_ff[0];
   assign rsp_count_ch1        = out_count_ff[1];
   assign rsp_count_ch2        = out_count_ff[2];
   assign rsp_count_ch3        = out_count_ff[3];
   assign rsp_count_ch4        = out_count_ff[4];
   assign rsp_count_ch5        = out_count_ff[5];

endmodule

`default_nettype wire
